@@ rtl/crtu_pkg.sv @@
// Shared types, action codes and constants for the call/return trace unit.
`default_nettype none

package crtu_pkg;

   // Symbol table depth used when the top level is not overridden
   localparam int unsigned MAX_SYMBOLS_DEF = 1024;

   // Reported depth and symbol index widths
   localparam int unsigned DEPTH_W   = 10;
   localparam int unsigned IDX_OUT_W = 10;
   localparam logic [DEPTH_W-1:0] DEPTH_TOP = 10'd1023;

   // Item action codes
   localparam logic [2:0] ACT_CLEAR = 3'd0;
   localparam logic [2:0] ACT_LOAD  = 3'd1;
   localparam logic [2:0] ACT_JAL   = 3'd2;
   localparam logic [2:0] ACT_JALR  = 3'd3;
   localparam logic [2:0] ACT_RET   = 3'd4;
   localparam logic [2:0] ACT_PUSH  = 3'd5;
   localparam logic [2:0] ACT_POP   = 3'd6;

   // Register numbers that classify a jalr
   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;

   // Event kinds in a result item
   localparam logic KIND_CALL = 1'b0;
   localparam logic KIND_RET  = 1'b1;

   typedef struct packed {
      logic [2:0]         action;
      logic [31:0]        pc;
      logic [31:0]        target;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg;
      logic signed [31:0] offset;
      logic [31:0]        load_start;
      logic [31:0]        load_size;
   } req_type;

   typedef struct packed {
      logic                 event_kind;
      logic [31:0]          event_pc;
      logic [31:0]          event_target;
      logic [DEPTH_W-1:0]   depth_shown;
      logic                 found;
      logic [IDX_OUT_W-1:0] symbol_index;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;
      logic load;
      logic push;
      logic pop;
      logic ev_start;
      logic ev_ret;
      logic step;
      logic emit;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic empty;
      logic done;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/call_return_trace_unit.sv @@
// Top level of the call/return trace unit: controller plus datapath.
// Clear, load, push and pop items do not start a search; busy stays low after them.
// A call or return on a loaded table of n entries holds busy while the binary search makes
// at most r = ceil(log2(n + 1)) reads, one read per cycle from the symbol memory;
// rsp_strobe pulses high as busy drops.
// Synchronous reset empties the table and zeroes the depth; table contents are not cleared.
`default_nettype none

module call_return_trace_unit #(
   parameter int unsigned MAX_SYMBOLS = crtu_pkg::MAX_SYMBOLS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  crtu_pkg::req_type req_item,
   output logic              rsp_strobe,
   output crtu_pkg::rsp_type rsp_item
);
   import crtu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   crtu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   crtu_dpath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

@@ rtl/crtu_ctrl.sv @@
// Controller: decodes accepted items and sequences the symbol search.
`default_nettype none

module crtu_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  crtu_pkg::req_type req_item,
   input  crtu_pkg::stat_type stat,
   output crtu_pkg::cmd_type cmd,
   output logic              busy
);
   import crtu_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_SEARCH = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;
   logic jalr_ret;
   logic jalr_call;
   logic is_call;
   logic is_ret;

   // Classify jalr by its register fields and immediate
   assign jalr_ret  = (req_item.dest_reg == REG_ZERO) && (req_item.src_reg == REG_RA) &&
                      (req_item.offset == 32'sd0);
   assign jalr_call = (req_item.dest_reg == REG_RA) ||
                      ((req_item.dest_reg == REG_ZERO) && (req_item.src_reg != REG_RA));

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Decode item, issue commands, advance state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      is_call  = 1'b0;
      is_ret   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_item.action)
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_LOAD:  cmd.load  = 1'b1;
                  ACT_JAL:   is_call   = 1'b1;
                  ACT_JALR: begin
                     is_ret  = jalr_ret;
                     is_call = !jalr_ret && jalr_call;
                  end
                  ACT_RET:   is_ret    = 1'b1;
                  ACT_PUSH:  cmd.push  = 1'b1;
                  ACT_POP:   cmd.pop   = 1'b1;
                  default:   ;
               endcase
               if ((is_call || is_ret) && !stat.empty) begin
                  cmd.ev_start = 1'b1;
                  cmd.ev_ret   = is_ret;
                  state_in     = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            cmd.step = 1'b1;
            if (stat.done) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   // A jal on a loaded table must start a search
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.action == ACT_JAL) && !stat.empty) |=> busy)
      else $error("jal on loaded table did not start a search");
`endif

endmodule

`default_nettype wire

@@ rtl/crtu_dpath.sv @@
// Datapath: symbol memories, call depth, binary search and result register.
`default_nettype none

module crtu_dpath #(
   parameter int unsigned MAX_SYMBOLS = crtu_pkg::MAX_SYMBOLS_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  crtu_pkg::req_type  req_item,
   input  crtu_pkg::cmd_type  cmd,
   output crtu_pkg::stat_type stat,
   output logic               rsp_strobe,
   output crtu_pkg::rsp_type  rsp_item
);
   import crtu_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS);
   localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int unsigned EXT_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SYMBOLS);

   // Symbol table memories
   logic [31:0] start_mem [MAX_SYMBOLS];
   logic [31:0] size_mem  [MAX_SYMBOLS];

   logic [CNT_W-1:0]   count_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_inc;
   logic [DEPTH_W-1:0] depth_dec;

   // Event being traced
   logic               kind_ff;
   logic [31:0]        pc_ff;
   logic [31:0]        target_ff;
   logic [31:0]        addr_ff;
   logic [DEPTH_W-1:0] shown_ff;

   // Search state
   logic [CNT_W-1:0] lo_ff;
   logic [CNT_W-1:0] hi_ff;
   logic [CNT_W-1:0] lo_in;
   logic [CNT_W-1:0] hi_in;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid_ff;
   logic [IDX_W-1:0] mid_in;
   logic             rd_valid_ff;
   logic [31:0]      rd_start_ff;
   logic [31:0]      rd_size_ff;
   logic             go_right;
   logic             issue;

   // Last entry whose start was not above the address
   logic [31:0]      cand_start_ff;
   logic [31:0]      cand_size_ff;
   logic [IDX_W-1:0] cand_idx_ff;

   // Range check and result
   logic [32:0]      cand_end;
   logic             hit;
   logic [EXT_W-1:0] idx_ext;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             strobe_ff;

   assign depth_inc = (depth_ff == DEPTH_TOP) ? depth_ff : depth_ff + DEPTH_W'(1);
   assign depth_dec = (depth_ff == '0) ? depth_ff : depth_ff - DEPTH_W'(1);

   // Narrow the bounds from the entry just read, pick the next probe
   always_comb begin
      go_right = (rd_start_ff <= addr_ff);
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (rd_valid_ff) begin
         if (go_right) begin
            lo_in = CNT_W'(mid_ff) + CNT_W'(1);
         end else begin
            hi_in = CNT_W'(mid_ff);
         end
      end
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in  = mid_sum[IDX_W:1];
      issue   = cmd.step && (lo_in < hi_in);
   end

   assign stat.empty = (count_ff == '0);
   assign stat.done  = !rd_valid_ff && (lo_ff >= hi_ff);

   // Write on load, read at the probe index
   always_ff @(posedge clock) begin
      if (cmd.load && (count_ff < CNT_MAX)) begin
         start_mem[count_ff[IDX_W-1:0]] <= req_item.load_start;
         size_mem[count_ff[IDX_W-1:0]]  <= req_item.load_size;
      end
      if (issue) begin
         rd_start_ff <= start_mem[mid_in];
         rd_size_ff  <= size_mem[mid_in];
      end
   end

   // Table fill count and call depth
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         depth_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
         depth_ff <= '0;
      end else begin
         if (cmd.load && (count_ff < CNT_MAX)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.push || (cmd.ev_start && !cmd.ev_ret)) begin
            depth_ff <= depth_inc;
         end else if (cmd.pop || (cmd.ev_start && cmd.ev_ret)) begin
            depth_ff <= depth_dec;
         end
      end
   end

   // Latch the event at accept
   always_ff @(posedge clock) begin
      if (cmd.ev_start) begin
         kind_ff   <= cmd.ev_ret ? KIND_RET : KIND_CALL;
         pc_ff     <= req_item.pc;
         target_ff <= cmd.ev_ret ? 32'd0 : req_item.target;
         addr_ff   <= cmd.ev_ret ? req_item.pc : req_item.target;
         shown_ff  <= cmd.ev_ret ? depth_dec : depth_ff;
      end
   end

   // Search bounds and probe tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff       <= '0;
         hi_ff       <= '0;
         rd_valid_ff <= 1'b0;
      end else if (cmd.ev_start) begin
         lo_ff       <= '0;
         hi_ff       <= count_ff;
         rd_valid_ff <= 1'b0;
      end else if (cmd.step) begin
         lo_ff       <= lo_in;
         hi_ff       <= hi_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         mid_ff <= mid_in;
      end
      if (cmd.step && rd_valid_ff && go_right) begin
         cand_start_ff <= rd_start_ff;
         cand_size_ff  <= rd_size_ff;
         cand_idx_ff   <= mid_ff;
      end
   end

   // Check start <= addr < start + size in 33 bits and build the item
   always_comb begin
      cand_end = {1'b0, cand_start_ff} + {1'b0, cand_size_ff};
      hit      = (lo_ff != '0) && (addr_ff >= cand_start_ff) &&
                 ({1'b0, addr_ff} < cand_end);
      idx_ext  = EXT_W'(cand_idx_ff);
      rsp_in.event_kind   = kind_ff;
      rsp_in.event_pc     = pc_ff;
      rsp_in.event_target = target_ff;
      rsp_in.depth_shown  = shown_ff;
      rsp_in.found        = hit;
      rsp_in.symbol_index = hit ? idx_ext[IDX_OUT_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // Bounds never cross
   assert property (@(posedge clock) disable iff (reset) lo_ff <= hi_ff)
      else $error("search bounds crossed");

   // An outstanding probe lies inside the current bounds
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((CNT_W'(mid_ff) >= lo_ff) && (CNT_W'(mid_ff) < hi_ff)))
      else $error("probe index outside search bounds");

   // Results are never on consecutive cycles
   assert property (@(posedge clock) disable iff (reset) strobe_ff |=> !strobe_ff)
      else $error("result strobe held for two cycles");

   // Fill count stays within the table
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_MAX)
      else $error("symbol count beyond table depth");
`endif

endmodule

`default_nettype wire

@@ tb/call_return_trace_unit_test.sv @@
// Self-checking testbench for the call/return trace unit: directed script, then random phases.
`timescale 1ns / 1ps

module call_return_trace_unit_test;
   import crtu_pkg::*;

   localparam int unsigned TBL_DEPTH    = MAX_SYMBOLS_DEF;
   localparam int          RANDOM_ITEMS = 1000;
   localparam int          CYCLE_LIMIT  = 500000;
   localparam int          SETTLE       = 32;
   localparam logic [2:0]  ACT_UNUSED   = 3'd7;

   // One row of the directed script: the item, and an expectation when typed in
   typedef struct packed {
      req_type item;
      logic    typed;
      logic    has;
      rsp_type rsp;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   call_return_trace_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #1 clock = ~clock;

   // Tracer state as the block should hold it
   logic [31:0]        tbl_start [TBL_DEPTH];
   logic [31:0]        tbl_size  [TBL_DEPTH];
   int unsigned        tbl_count = 0;
   logic [DEPTH_W-1:0] depth_now = '0;

   // Stimulus-side copy of the loaded entries, used to aim addresses
   logic [31:0] aim_start [$];
   logic [31:0] aim_size  [$];

   rsp_type pending_events [$];
   logic    row_typed = 1'b0;
   logic    row_has   = 1'b0;
   rsp_type row_rsp   = '0;

   int   errors          = 0;
   int   accepted        = 0;
   int   useful_items    = 0;
   int   bulk_items      = 0;
   int   results_checked = 0;
   int   largest_tbl     = 0;
   int   cycle_count     = 0;
   int   burst_left      = 0;
   logic gaps_on         = 1'b1;
   logic top_reached     = 1'b0;

   // ---------------------------------------------------------------- predictor

   // Binary search for the last start not above addr, then a 33-bit range test
   function automatic void find_entry(input logic [31:0] addr, output logic hit,
                                      output logic [IDX_OUT_W-1:0] idx);
      int unsigned lo, hi, mid, k;
      logic [32:0] first, past;
      lo = 0;
      hi = tbl_count;
      hit = 1'b0;
      idx = '0;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (tbl_start[mid] <= addr) lo = mid + 1;
         else hi = mid;
      end
      if (hi != 0) begin
         k = hi - 1;
         first = {1'b0, tbl_start[k]};
         past = first + {1'b0, tbl_size[k]};
         if ({1'b0, addr} >= first && {1'b0, addr} < past) begin
            hit = 1'b1;
            idx = k[IDX_OUT_W-1:0];
         end
      end
   endfunction

   // Report the depth, then raise it with saturation
   function automatic rsp_type call_event(input req_type it);
      rsp_type r;
      logic hit;
      logic [IDX_OUT_W-1:0] idx;
      r = '0;
      r.event_kind = KIND_CALL;
      r.event_pc = it.pc;
      r.event_target = it.target;
      r.depth_shown = depth_now;
      find_entry(it.target, hit, idx);
      r.found = hit;
      r.symbol_index = idx;
      if (depth_now != DEPTH_TOP) depth_now++;
      if (depth_now == DEPTH_TOP) top_reached = 1'b1;
      return r;
   endfunction

   // Lower the depth without going below zero, then report it
   function automatic rsp_type return_event(input req_type it);
      rsp_type r;
      logic hit;
      logic [IDX_OUT_W-1:0] idx;
      r = '0;
      if (depth_now != 0) depth_now--;
      r.event_kind = KIND_RET;
      r.event_pc = it.pc;
      r.event_target = '0;
      r.depth_shown = depth_now;
      find_entry(it.pc, hit, idx);
      r.found = hit;
      r.symbol_index = idx;
      return r;
   endfunction

   // Advance the tracer state by one item and give the result it causes, if any
   function automatic void track_item(input req_type it, output logic has, output rsp_type r);
      has = 1'b0;
      r = '0;
      case (it.action)
         ACT_CLEAR: begin
            tbl_count = 0;
            depth_now = '0;
         end
         ACT_LOAD: begin
            if (tbl_count < TBL_DEPTH) begin
               tbl_start[tbl_count] = it.load_start;
               tbl_size[tbl_count] = it.load_size;
               tbl_count++;
               if (tbl_count > largest_tbl) largest_tbl = tbl_count;
            end
         end
         ACT_JAL: begin
            if (tbl_count != 0) begin
               r = call_event(it);
               has = 1'b1;
            end
         end
         ACT_JALR: begin
            if (tbl_count != 0) begin
               if (it.dest_reg == REG_ZERO && it.src_reg == REG_RA && it.offset == 0) begin
                  r = return_event(it);
                  has = 1'b1;
               end else if (it.dest_reg == REG_RA ||
                            (it.dest_reg == REG_ZERO && it.src_reg != REG_RA)) begin
                  r = call_event(it);
                  has = 1'b1;
               end
            end
         end
         ACT_RET: begin
            if (tbl_count != 0) begin
               r = return_event(it);
               has = 1'b1;
            end
         end
         ACT_PUSH: begin
            if (depth_now != DEPTH_TOP) depth_now++;
            if (depth_now == DEPTH_TOP) top_reached = 1'b1;
         end
         ACT_POP: begin
            if (depth_now != 0) depth_now--;
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic show_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got)
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
   endtask

   // Compare one result with the oldest pending expectation
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_events.size() == 0) begin
         errors++;
         $display("%0t: result with no item pending: expected none, actual %h", $time, got);
      end else begin
         want = pending_events.pop_front();
         results_checked++;
         if (got !== want) begin
            errors++;
            show_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            show_field("event_pc", want.event_pc, got.event_pc);
            show_field("event_target", want.event_target, got.event_target);
            show_field("depth_shown", 32'(want.depth_shown), 32'(got.depth_shown));
            show_field("found", 32'(want.found), 32'(got.found));
            show_field("symbol_index", 32'(want.symbol_index), 32'(got.symbol_index));
         end
      end
   endtask

   // Check results, then record each accepted item
   always @(posedge clock) begin
      logic    has;
      rsp_type r;
      if (!reset) begin
         if (rsp_strobe === 1'b1) check_result(rsp_item);
         if (start && busy === 1'b0) begin
            accepted++;
            track_item(req_item, has, r);
            if (has || req_item.action == ACT_CLEAR || req_item.action == ACT_LOAD ||
                req_item.action == ACT_PUSH || req_item.action == ACT_POP)
               useful_items++;
            if (row_typed) begin
               if (row_has) pending_events.push_back(row_rsp);
            end else if (has) begin
               pending_events.push_back(r);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results pending", $time, pending_events.size());
         $display("[call_return_trace_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic req_type mk_req(input logic [2:0] act, input logic [31:0] pc,
                                      input logic [31:0] tgt, input logic [4:0] rd,
                                      input logic [4:0] rs1, input logic [31:0] off,
                                      input logic [31:0] ls, input logic [31:0] lsz);
      req_type it;
      it.action = act;
      it.pc = pc;
      it.target = tgt;
      it.dest_reg = rd;
      it.src_reg = rs1;
      it.offset = off;
      it.load_start = ls;
      it.load_size = lsz;
      return it;
   endfunction

   function automatic rsp_type mk_rsp(input logic kind, input logic [31:0] pc,
                                      input logic [31:0] tgt, input logic [DEPTH_W-1:0] dep,
                                      input logic hit, input logic [IDX_OUT_W-1:0] idx);
      rsp_type r;
      r.event_kind = kind;
      r.event_pc = pc;
      r.event_target = tgt;
      r.depth_shown = dep;
      r.found = hit;
      r.symbol_index = idx;
      return r;
   endfunction

   function automatic script_row_type typed_row(input req_type it, input logic has,
                                                input rsp_type r);
      return '{item: it, typed: 1'b1, has: has, rsp: r};
   endfunction

   function automatic script_row_type model_row(input req_type it);
      return '{item: it, typed: 1'b0, has: 1'b0, rsp: '0};
   endfunction

   // Hold start low for a random gap at the end of each burst
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         if (gaps_on) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 16);
            repeat (gap) @(negedge clock) start <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Present one item and wait until it is taken
   task automatic send_item(input script_row_type row);
      pace();
      @(negedge clock);
      req_item <= row.item;
      start <= 1'b1;
      row_typed = row.typed;
      row_has = row.has;
      row_rsp = row.rsp;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // Pause the sender until every pending result has arrived
   task automatic drain();
      @(negedge clock) start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type random_req();
      req_type it;
      it.action = 3'($urandom_range(0, 7));
      it.pc = $urandom;
      it.target = $urandom;
      it.dest_reg = 5'($urandom);
      it.src_reg = 5'($urandom);
      it.offset = $urandom;
      it.load_start = $urandom;
      it.load_size = $urandom;
      return it;
   endfunction

   function automatic logic [31:0] random_offset();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Aim mostly at loaded entries and their edges, sometimes anywhere
   function automatic logic [31:0] pick_addr();
      int unsigned k;
      logic [31:0] s, z;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0 || aim_start.size() == 0) return $urandom;
      if (sel == 1) return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hFFFF_FFFF;
      k = $urandom_range(0, aim_start.size() - 1);
      s = aim_start[k];
      z = aim_size[k];
      case ($urandom_range(0, 4))
         0: return s;
         1: return s - 1;
         2: return s + z;
         3: return s + z - 1;
         default: return (z == 0) ? s : s + ($urandom % z);
      endcase
   endfunction

   task automatic add_entry(input logic [31:0] s, input logic [31:0] z);
      req_type it;
      it = random_req();
      it.action = ACT_LOAD;
      it.load_start = s;
      it.load_size = z;
      send_item(model_row(it));
      if (aim_start.size() < TBL_DEPTH) begin
         aim_start.push_back(s);
         aim_size.push_back(z);
      end
   endtask

   // Clear, then load n entries, ascending unless asked otherwise
   task automatic load_table(input int n, input logic sorted);
      req_type it;
      logic [31:0] addr, spread, z;
      int i;
      it = random_req();
      it.action = ACT_CLEAR;
      send_item(model_row(it));
      aim_start.delete();
      aim_size.delete();
      addr = $urandom >> $urandom_range(0, 31);
      spread = (32'hFFFF_FFFF - addr) / (n + 1);
      for (i = 0; i < n; i++) begin
         if (sorted) addr = addr + $urandom_range(0, spread);
         else addr = $urandom;
         case ($urandom_range(0, 7))
            0: z = $urandom;
            1: z = '0;
            2: z = spread;
            default: z = $urandom_range(1, 64) + (spread >> $urandom_range(1, 8));
         endcase
         add_entry(addr, z);
      end
      bulk_items += n + 1;
   endtask

   task automatic repeat_action(input logic [2:0] act, input int n);
      req_type it;
      repeat (n) begin
         it = random_req();
         it.action = act;
         send_item(model_row(it));
      end
      bulk_items += n;
   endtask

   // Mostly well-formed calls and returns, some depth moves and noise
   task automatic event_burst(input int n);
      req_type it;
      int sel;
      repeat (n) begin
         it = random_req();
         sel = $urandom_range(0, 39);
         if (sel < 12) begin
            it.action = ACT_JAL;
            it.target = pick_addr();
         end else if (sel < 22) begin
            it.action = ACT_JALR;
            it.pc = pick_addr();
            it.target = pick_addr();
            it.offset = random_offset();
            case ($urandom_range(0, 4))
               0: begin
                  it.dest_reg = REG_ZERO;
                  it.src_reg = REG_RA;
                  it.offset = '0;
               end
               1: it.dest_reg = REG_RA;
               2: begin
                  it.dest_reg = REG_ZERO;
                  if (it.src_reg == REG_RA) it.src_reg = REG_ZERO;
               end
               3: begin
                  it.dest_reg = REG_ZERO;
                  it.src_reg = REG_RA;
                  if (it.offset == 0) it.offset = 32'h1;
               end
               default: ;
            endcase
         end else if (sel < 31) begin
            it.action = ACT_RET;
            it.pc = pick_addr();
         end else if (sel < 34) begin
            it.action = ACT_PUSH;
         end else if (sel < 37) begin
            it.action = ACT_POP;
         end else if (sel == 37) begin
            it.action = ACT_UNUSED;
         end
         if (sel == 38) begin
            add_entry($urandom, $urandom_range(0, 4096));
         end else if (sel == 39) begin
            it.action = ACT_CLEAR;
            send_item(model_row(it));
            aim_start.delete();
            aim_size.delete();
         end else begin
            send_item(model_row(it));
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      script_row_type script [$];
      int phase_no;
      int base_useful;
      int sel;

      // Empty table, depth moves and an unused code: none of these report
      script.push_back(typed_row(mk_req(ACT_JAL, 32'h100, 32'h200, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_RET, 32'h104, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_JALR, 32'h108, 32'h300, REG_RA, 5'd2, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_PUSH, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_POP, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 5'd31,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                                 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_UNUSED, 32'h10, 32'h10, 5'd1, 5'd1, 32'h0,
                                        32'h0, 32'h10), 1'b0, '0));
      // Three entries, the last one reaching past the top of the address space
      script.push_back(typed_row(mk_req(ACT_LOAD, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h10), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_LOAD, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h1000, 32'h100), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_LOAD, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'hFFFF_FF00, 32'hFFFF_FFFF), 1'b0, '0));
      // Calls at the address extremes and just past an entry
      script.push_back(typed_row(mk_req(ACT_JAL, 32'h0, 32'h1000, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_CALL, 32'h0, 32'h1000, 10'd0, 1'b1, 10'd1)));
      script.push_back(typed_row(mk_req(ACT_JAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 5'd0,
                                        32'h0, 32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_CALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1,
                                        1'b1, 10'd2)));
      script.push_back(typed_row(mk_req(ACT_JAL, 32'h20, 32'h10, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_CALL, 32'h20, 32'h10, 10'd2, 1'b0, 10'd0)));
      // Returns by ret and by the jalr return form
      script.push_back(typed_row(mk_req(ACT_RET, 32'h1050, 32'hDEAD_BEEF, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_RET, 32'h1050, 32'h0, 10'd2, 1'b1, 10'd1)));
      script.push_back(typed_row(mk_req(ACT_JALR, 32'h5, 32'hABCD, REG_ZERO, REG_RA, 32'h0,
                                        32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_RET, 32'h5, 32'h0, 10'd1, 1'b1, 10'd0)));
      // Jalr forms that are neither call nor return
      script.push_back(typed_row(mk_req(ACT_JALR, 32'h30, 32'h1001, REG_ZERO, REG_RA,
                                        32'h8000_0000, 32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_JALR, 32'h34, 32'h1001, 5'd5, 5'd3, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      // Jalr calls through a non-link base and through the link register, then a jalr that is neither
      script.push_back(typed_row(mk_req(ACT_JALR, 32'h40, 32'h800, REG_ZERO, 5'd31,
                                        32'hFFFF_FFFF, 32'h0, 32'h0), 1'b1,
                                 mk_rsp(KIND_CALL, 32'h40, 32'h800, 10'd1, 1'b0, 10'd0)));
      script.push_back(model_row(mk_req(ACT_JALR, 32'h44, 32'hFFFF_FF00, REG_RA, REG_RA,
                                        32'h7FFF_FFFF, 32'h0, 32'h0)));
      script.push_back(model_row(mk_req(ACT_JALR, 32'h48, 32'h1000, 5'd31, REG_ZERO, 32'h0,
                                        32'h0, 32'h0)));
      // Out-of-order entry, then lookups over the unsorted table
      script.push_back(model_row(mk_req(ACT_LOAD, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h10, 32'h8)));
      script.push_back(model_row(mk_req(ACT_JAL, 32'h4C, 32'h12, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0)));
      script.push_back(model_row(mk_req(ACT_RET, 32'h14, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0)));
      // Clear empties the table again
      script.push_back(typed_row(mk_req(ACT_CLEAR, 32'h0, 32'h0, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));
      script.push_back(typed_row(mk_req(ACT_JAL, 32'h50, 32'h1000, 5'd0, 5'd0, 32'h0,
                                        32'h0, 32'h0), 1'b0, '0));

      // Hold reset, then release it at a falling edge
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_item(script[i]);
      drain();

      // Random phases until enough mixed items have gone through
      base_useful = useful_items;
      phase_no = 0;
      while (useful_items - bulk_items - base_useful < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         case (phase_no)
            2: load_table(TBL_DEPTH + 6, 1'b1);
            4: begin
               load_table($urandom_range(1, 8), 1'b1);
               repeat_action(ACT_PUSH, TBL_DEPTH + 6);
               event_burst(30);
               repeat_action(ACT_POP, TBL_DEPTH + 6);
            end
            default: begin
               sel = $urandom_range(0, 9);
               if (sel == 0) load_table(0, 1'b1);
               else if (sel < 8) load_table($urandom_range(1, 16), 1'b1);
               else if (sel == 8) load_table($urandom_range(17, 100), 1'b1);
               else load_table($urandom_range(2, 12), 1'b0);
            end
         endcase
         event_burst($urandom_range(20, 60));
         if (phase_no == 2 || $urandom_range(0, 2) == 0) drain();
         phase_no++;
      end

      // Let every pending result arrive, then give the block time to settle
      @(negedge clock) start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d items in %0d random phases, %0d trace results checked",
               accepted, phase_no, results_checked);
      $display("largest table %0d entries, depth top %s, %0d mismatches",
               largest_tbl, top_reached ? "reached" : "not reached", errors);
      if (errors == 0 && pending_events.size() == 0)
         $display("[call_return_trace_unit] OK");
      else
         $display("[call_return_trace_unit] ERROR");
      $finish;
   end

endmodule
